FILE: rtl/alqr_pkg.sv
// ----------------------------------------------------------------------------
// alqr_pkg
// Shared types, command codes and constant tables of the attitude LQR block.
// ----------------------------------------------------------------------------
package alqr_pkg;

    localparam int NUM_MOTORS  = 8;
    localparam int SQRT_STEPS  = 23;
    localparam int DIV_STEPS   = 16;
    localparam int HORNER_LAST = 4;
    localparam int TERM_LAST   = 4;

    localparam logic signed [15:0] TARGET_ROLL_RST  = 16'sd3317;
    localparam logic signed [15:0] TARGET_PITCH_RST = -16'sd3217;
    localparam logic [14:0]        START_THR_RST    = 15'd41;
    localparam logic [14:0]        STOP_THR_RST     = 15'd410;
    localparam logic [15:0]        FULL_SCALE_RST   = 16'd1000;
    localparam logic [23:0]        INV_THRUST_RST   = 24'd1000000;

    // squared speed limit, 1024 rps in Q24
    localparam logic [57:0] SPEED_SQ_LIMIT = 58'd1 << 44;
    localparam logic [23:0] MV_SCALE       = 24'd1000;

    typedef enum logic [2:0] {
        REG_VERTEX_MODE  = 3'd0,
        REG_TARGET_ROLL  = 3'd1,
        REG_TARGET_PITCH = 3'd2,
        REG_START_THR    = 3'd3,
        REG_STOP_THR     = 3'd4,
        REG_FULL_SCALE   = 3'd5,
        REG_INV_THRUST   = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic              vertex_mode;
        logic signed [15:0] target_roll;
        logic signed [15:0] target_pitch;
        logic [14:0]       arm_threshold;
        logic [14:0]       stop_threshold;
        logic [15:0]       pwm_full_scale;
        logic [23:0]       inverse_thrust_coeff;
    } cfg_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_WB,
        OP_SQ_LOAD,
        OP_SQ_STEP,
        OP_ARM,
        OP_ACC_INIT,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DUTY,
        OP_PUBLISH
    } op_t;

    // operand pair of the shared multiplier, also the write-back target
    typedef enum logic [3:0] {
        SEL_EX2,
        SEL_EY2,
        SEL_TRM,
        SEL_FORCE,
        SEL_S2,
        SEL_HORN,
        SEL_MV,
        SEL_X,
        SEL_Y
    } sel_t;

    typedef struct packed {
        op_t        op;
        sel_t       sel;
        logic [2:0] idx;
        logic [2:0] motor;
    } cmd_t;

    typedef struct packed {
        logic drive;
    } sts_t;

    // motor mixing weights, Q16
    function automatic logic signed [18:0] mix_weight(input logic [2:0] m);
        logic signed [18:0] w;
        case (m)
            3'd0:    w = -19'sd239206;
            3'd1:    w = 19'sd73518;
            3'd2:    w = 19'sd64094;
            3'd3:    w = 19'sd101594;
            3'd4:    w = -19'sd51223;
            3'd5:    w = 19'sd23147;
            3'd6:    w = 19'sd114465;
            3'd7:    w = -19'sd86396;
            default: w = 19'sd0;
        endcase
        return w;
    endfunction

    // lqr gains, Q16; edge mode uses only the first two terms
    function automatic logic signed [17:0] lqr_gain(input logic vertex,
                                                    input logic [2:0] k);
        logic signed [17:0] g;
        g = 18'sd0;
        if (vertex) begin
            case (k)
                3'd0:    g = 18'sd25651;
                3'd1:    g = 18'sd49552;
                3'd2:    g = -18'sd79;
                3'd3:    g = -18'sd14202;
                3'd4:    g = 18'sd26;
                default: g = 18'sd0;
            endcase
        end else begin
            case (k)
                3'd0:    g = 18'sd73656;
                3'd1:    g = -18'sd14261;
                default: g = 18'sd0;
            endcase
        end
        return g;
    endfunction

    // quartic coefficients, Q40, highest order first
    function automatic logic signed [63:0] volt_coef(input logic [2:0] k);
        logic signed [63:0] c;
        case (k)
            3'd0:    c = 64'sd2415;
            3'd1:    c = -64'sd1289837;
            3'd2:    c = 64'sd261364910;
            3'd3:    c = -64'sd14953358138;
            3'd4:    c = 64'sd586149649000;
            default: c = 64'sd0;
        endcase
        return c;
    endfunction

    function automatic logic [16:0] abs17(input logic signed [16:0] v);
        return v[16] ? 17'(-v) : 17'(v);
    endfunction

endpackage

FILE: rtl/alqr_cfg.sv
// ----------------------------------------------------------------------------
// alqr_cfg
// APB configuration registers.
// ----------------------------------------------------------------------------
module alqr_cfg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output alqr_pkg::cfg_t      cfg
);

    alqr_pkg::cfg_t   cfg_reg;
    alqr_pkg::reg_idx_t idx;
    logic             wr_en;

    assign idx    = alqr_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.vertex_mode          <= 1'b0;
            cfg_reg.target_roll          <= alqr_pkg::TARGET_ROLL_RST;
            cfg_reg.target_pitch         <= alqr_pkg::TARGET_PITCH_RST;
            cfg_reg.arm_threshold        <= alqr_pkg::START_THR_RST;
            cfg_reg.stop_threshold       <= alqr_pkg::STOP_THR_RST;
            cfg_reg.pwm_full_scale       <= alqr_pkg::FULL_SCALE_RST;
            cfg_reg.inverse_thrust_coeff <= alqr_pkg::INV_THRUST_RST;
        end else if (wr_en) begin
            case (idx)
                alqr_pkg::REG_VERTEX_MODE:  cfg_reg.vertex_mode <= pwdata[0];
                alqr_pkg::REG_TARGET_ROLL:  cfg_reg.target_roll <= pwdata[15:0];
                alqr_pkg::REG_TARGET_PITCH: cfg_reg.target_pitch <= pwdata[15:0];
                alqr_pkg::REG_START_THR:    cfg_reg.arm_threshold <= pwdata[14:0];
                alqr_pkg::REG_STOP_THR:     cfg_reg.stop_threshold <= pwdata[14:0];
                alqr_pkg::REG_FULL_SCALE:   cfg_reg.pwm_full_scale <= pwdata[15:0];
                alqr_pkg::REG_INV_THRUST:   cfg_reg.inverse_thrust_coeff <= pwdata[23:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            alqr_pkg::REG_VERTEX_MODE:  prdata = 32'(cfg_reg.vertex_mode);
            alqr_pkg::REG_TARGET_ROLL:  prdata = 32'(cfg_reg.target_roll);
            alqr_pkg::REG_TARGET_PITCH: prdata = 32'(cfg_reg.target_pitch);
            alqr_pkg::REG_START_THR:    prdata = 32'(cfg_reg.arm_threshold);
            alqr_pkg::REG_STOP_THR:     prdata = 32'(cfg_reg.stop_threshold);
            alqr_pkg::REG_FULL_SCALE:   prdata = 32'(cfg_reg.pwm_full_scale);
            alqr_pkg::REG_INV_THRUST:   prdata = 32'(cfg_reg.inverse_thrust_coeff);
            default:                    prdata = 32'd0;
        endcase
    end

endmodule

FILE: rtl/alqr_dp.sv
// ----------------------------------------------------------------------------
// alqr_dp
// Datapath: shared multiplier, square root and divider with working registers.
// ----------------------------------------------------------------------------
module alqr_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  alqr_pkg::cfg_t       cfg,
    input  alqr_pkg::cmd_t       cmd,
    output alqr_pkg::sts_t       sts,
    input  logic signed [15:0]   roll_angle,
    input  logic signed [15:0]   pitch_angle,
    input  logic signed [15:0]   roll_rate,
    input  logic signed [15:0]   pitch_rate,
    input  logic signed [15:0]   yaw_rate,
    input  logic [15:0]          battery_mv,
    output logic [7:0][15:0]     duty,
    output logic                 driving
);

    // captured sample
    logic signed [16:0] ex_reg, ey_reg;
    logic signed [15:0] gx_reg, gy_reg, gz_reg;
    logic [15:0]        bat_reg;

    // multiplier
    logic [55:0]        mul_a;
    logic [23:0]        mul_b;
    logic               mul_neg;
    logic [11:0]        digit;
    logic [67:0]        pp;
    logic [79:0]        prod_reg;
    logic               prod_neg_reg;
    logic [80:0]        prod_z;
    logic signed [80:0] sprod;
    logic signed [80:0] sprod_sh;

    // working values
    logic [33:0]        sumsq_reg;
    logic signed [36:0] torque_reg;
    logic               fpos_reg;
    logic [33:0]        fsh_reg;
    logic signed [63:0] acc_reg;
    logic [63:0]        acc_mag;
    logic [39:0]        mv_reg;
    logic [55:0]        x_reg;
    logic [31:0]        y_reg;
    logic [57:0]        s2_lim;

    // square root
    logic [45:0]        sq_x_reg;
    logic [24:0]        sq_rem_reg;
    logic [22:0]        sq_root_reg;
    logic [26:0]        sq_t;
    logic [26:0]        sq_trial;

    // divider
    logic [15:0]        drem_reg;
    logic [15:0]        dlo_reg;
    logic [15:0]        dq_reg;
    logic [16:0]        div_t;
    logic               sat;
    logic               acc_pos;

    // arming
    logic [16:0]        magv;
    logic               drive_reg;
    logic               armed_reg;
    logic               drive_now;

    logic [7:0][15:0]   duty_w_reg;
    logic [7:0][15:0]   duty_o_reg;
    logic               driving_o_reg;

    logic signed [16:0] term_st;
    logic signed [17:0] term_g;
    logic signed [18:0] weight;
    logic [16:0]        torque_mag_hi;

    assign acc_mag = acc_reg[63] ? 64'(-acc_reg) : 64'(acc_reg);
    assign weight  = alqr_pkg::mix_weight(cmd.motor);
    assign torque_mag_hi = '0;

    always_comb begin
        term_g = alqr_pkg::lqr_gain(cfg.vertex_mode, cmd.idx);
        term_st = 17'sd0;
        if (cfg.vertex_mode) begin
            case (cmd.idx)
                3'd0:    term_st = ex_reg;
                3'd1:    term_st = ey_reg;
                3'd2:    term_st = 17'(gx_reg);
                3'd3:    term_st = 17'(gy_reg);
                3'd4:    term_st = 17'(gz_reg);
                default: term_st = 17'sd0;
            endcase
        end else begin
            case (cmd.idx)
                3'd0:    term_st = ey_reg;
                3'd1:    term_st = 17'(gy_reg);
                default: term_st = 17'sd0;
            endcase
        end
    end

    // operand selection
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        case (cmd.sel)
            alqr_pkg::SEL_EX2: begin
                mul_a = 56'(alqr_pkg::abs17(ex_reg));
                mul_b = 24'(alqr_pkg::abs17(ex_reg));
            end
            alqr_pkg::SEL_EY2: begin
                mul_a = 56'(alqr_pkg::abs17(ey_reg));
                mul_b = 24'(alqr_pkg::abs17(ey_reg));
            end
            alqr_pkg::SEL_TRM: begin
                mul_a   = 56'(alqr_pkg::abs17(term_st));
                mul_b   = term_g[17] ? 24'(-term_g) : 24'(term_g);
                mul_neg = term_st[16] ^ term_g[17];
            end
            alqr_pkg::SEL_FORCE: begin
                mul_a   = torque_reg[36] ? 56'(-torque_reg) : 56'(torque_reg);
                mul_b   = weight[18] ? 24'(-weight) : 24'(weight);
                mul_neg = torque_reg[36] ^ weight[18];
            end
            alqr_pkg::SEL_S2: begin
                mul_a = 56'(fsh_reg);
                mul_b = cfg.inverse_thrust_coeff;
            end
            alqr_pkg::SEL_HORN: begin
                mul_a   = acc_mag[55:0];
                mul_b   = 24'(sq_root_reg);
                mul_neg = acc_reg[63];
            end
            alqr_pkg::SEL_MV: begin
                mul_a = acc_reg[55:0];
                mul_b = alqr_pkg::MV_SCALE;
            end
            alqr_pkg::SEL_X: begin
                mul_a = 56'(mv_reg);
                mul_b = 24'(cfg.pwm_full_scale);
            end
            alqr_pkg::SEL_Y: begin
                mul_a = 56'(bat_reg);
                mul_b = 24'(cfg.pwm_full_scale);
            end
            default: begin
            end
        endcase
    end

    assign digit    = (cmd.op == alqr_pkg::OP_MUL_HI) ? mul_b[23:12] : mul_b[11:0];
    assign pp       = 68'(mul_a) * 68'(digit);
    assign prod_z   = {1'b0, prod_reg};
    assign sprod    = prod_neg_reg ? -$signed(prod_z) : $signed(prod_z);
    assign sprod_sh = sprod >>> 12;
    assign s2_lim   = (prod_reg[57:0] > alqr_pkg::SPEED_SQ_LIMIT)
                      ? alqr_pkg::SPEED_SQ_LIMIT : prod_reg[57:0];

    assign sq_t     = {sq_rem_reg, sq_x_reg[45:44]};
    assign sq_trial = 27'({sq_root_reg, 2'b01});
    assign div_t    = {drem_reg, dlo_reg[15]};

    assign magv      = cfg.vertex_mode ? sq_root_reg[16:0] : alqr_pkg::abs17(ey_reg);
    assign drive_now = (armed_reg || (magv < 17'(cfg.arm_threshold)))
                       && (magv < 17'(cfg.stop_threshold));
    assign sat       = x_reg[55:16] >= 40'(y_reg);
    assign acc_pos   = !acc_reg[63] && (acc_reg != 64'sd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg <= 1'b0;
        end else if (cmd.op == alqr_pkg::OP_ARM) begin
            armed_reg <= drive_now;
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            alqr_pkg::OP_LOAD: begin
                ex_reg     <= 17'(cfg.target_roll) - 17'(roll_angle);
                ey_reg     <= 17'(cfg.target_pitch) - 17'(pitch_angle);
                gx_reg     <= roll_rate;
                gy_reg     <= pitch_rate;
                gz_reg     <= yaw_rate;
                bat_reg    <= battery_mv;
                torque_reg <= 37'sd0;
                duty_w_reg <= '0;
                drive_reg  <= 1'b0;
            end
            alqr_pkg::OP_MUL_LO: begin
                prod_reg     <= 80'(pp);
                prod_neg_reg <= mul_neg;
            end
            alqr_pkg::OP_MUL_HI: begin
                prod_reg <= prod_reg + (80'(pp) << 12);
            end
            alqr_pkg::OP_WB: begin
                case (cmd.sel)
                    alqr_pkg::SEL_EX2: sumsq_reg <= prod_reg[33:0];
                    alqr_pkg::SEL_EY2: sumsq_reg <= sumsq_reg + prod_reg[33:0];
                    alqr_pkg::SEL_TRM: torque_reg <= torque_reg + sprod[36:0];
                    alqr_pkg::SEL_FORCE: begin
                        fpos_reg <= !prod_neg_reg && (prod_reg != 80'd0);
                        fsh_reg  <= prod_reg[53:20];
                    end
                    alqr_pkg::SEL_S2: begin
                        sq_x_reg    <= fpos_reg ? 46'(s2_lim) : 46'd0;
                        sq_rem_reg  <= '0;
                        sq_root_reg <= '0;
                    end
                    alqr_pkg::SEL_HORN:
                        acc_reg <= sprod_sh[63:0] + alqr_pkg::volt_coef(cmd.idx);
                    alqr_pkg::SEL_MV: mv_reg <= prod_reg[63:24];
                    alqr_pkg::SEL_X:  x_reg <= prod_reg[55:0];
                    alqr_pkg::SEL_Y:  y_reg <= prod_reg[31:0];
                    default: begin
                    end
                endcase
            end
            alqr_pkg::OP_SQ_LOAD: begin
                sq_x_reg    <= 46'(sumsq_reg);
                sq_rem_reg  <= '0;
                sq_root_reg <= '0;
            end
            alqr_pkg::OP_SQ_STEP: begin
                if (sq_t >= sq_trial) begin
                    sq_rem_reg  <= 25'(sq_t - sq_trial);
                    sq_root_reg <= {sq_root_reg[21:0], 1'b1};
                end else begin
                    sq_rem_reg  <= sq_t[24:0];
                    sq_root_reg <= {sq_root_reg[21:0], 1'b0};
                end
                sq_x_reg <= sq_x_reg << 2;
            end
            alqr_pkg::OP_ARM: drive_reg <= drive_now;
            alqr_pkg::OP_ACC_INIT: acc_reg <= alqr_pkg::volt_coef(3'd0);
            alqr_pkg::OP_DIV_INIT: begin
                drem_reg <= x_reg[47:32];
                dlo_reg  <= x_reg[31:16];
                dq_reg   <= '0;
            end
            alqr_pkg::OP_DIV_STEP: begin
                if (div_t >= {1'b0, bat_reg}) begin
                    drem_reg <= 16'(div_t - {1'b0, bat_reg});
                    dq_reg   <= {dq_reg[14:0], 1'b1};
                end else begin
                    drem_reg <= div_t[15:0];
                    dq_reg   <= {dq_reg[14:0], 1'b0};
                end
                dlo_reg <= dlo_reg << 1;
            end
            alqr_pkg::OP_DUTY: begin
                if (!acc_pos)
                    duty_w_reg[cmd.motor] <= 16'd0;
                else if ((bat_reg == 16'd0) || sat)
                    duty_w_reg[cmd.motor] <= cfg.pwm_full_scale;
                else
                    duty_w_reg[cmd.motor] <= dq_reg;
            end
            alqr_pkg::OP_PUBLISH: begin
                duty_o_reg    <= duty_w_reg;
                driving_o_reg <= drive_reg;
            end
            default: begin
            end
        endcase
    end

    assign sts.drive = drive_reg | (|torque_mag_hi);
    assign duty      = duty_o_reg;
    assign driving   = driving_o_reg;

endmodule

FILE: rtl/alqr_ctrl.sv
// ----------------------------------------------------------------------------
// alqr_ctrl
// Sequencer: walks one sample through the datapath and runs both handshakes.
// ----------------------------------------------------------------------------
module alqr_ctrl #(
    parameter int MOTOR_COUNT = 8
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    input  alqr_pkg::sts_t  sts,
    output alqr_pkg::cmd_t  cmd
);

    localparam logic [2:0] LAST_MOTOR = 3'(MOTOR_COUNT - 1);
    localparam logic [4:0] SQ_LAST    = 5'(alqr_pkg::SQRT_STEPS - 1);
    localparam logic [4:0] DIV_LAST   = 5'(alqr_pkg::DIV_STEPS - 1);
    localparam logic [2:0] HORN_LAST  = 3'(alqr_pkg::HORNER_LAST);
    localparam logic [2:0] TRM_LAST   = 3'(alqr_pkg::TERM_LAST);

    typedef enum logic [3:0] {
        S_IDLE, S_MLO, S_MHI, S_WB, S_SQLD, S_SQ, S_ARM, S_CHK,
        S_AINIT, S_DINIT, S_DIV, S_DUTY, S_PUB
    } state_t;

    state_t          state_reg;
    alqr_pkg::sel_t  sel_reg;
    logic [2:0]      idx_reg;
    logic [2:0]      motor_reg;
    logic [4:0]      cnt_reg;
    logic            s_ready_reg;
    logic            m_valid_reg;
    logic            accept;
    logic            out_free;

    assign accept   = s_valid && s_ready_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = s_ready_reg;
    assign m_valid  = m_valid_reg;

    always_comb begin
        cmd.sel   = sel_reg;
        cmd.idx   = idx_reg;
        cmd.motor = motor_reg;
        case (state_reg)
            S_IDLE:  cmd.op = accept ? alqr_pkg::OP_LOAD : alqr_pkg::OP_NOP;
            S_MLO:   cmd.op = alqr_pkg::OP_MUL_LO;
            S_MHI:   cmd.op = alqr_pkg::OP_MUL_HI;
            S_WB:    cmd.op = alqr_pkg::OP_WB;
            S_SQLD:  cmd.op = alqr_pkg::OP_SQ_LOAD;
            S_SQ:    cmd.op = alqr_pkg::OP_SQ_STEP;
            S_ARM:   cmd.op = alqr_pkg::OP_ARM;
            S_AINIT: cmd.op = alqr_pkg::OP_ACC_INIT;
            S_DINIT: cmd.op = alqr_pkg::OP_DIV_INIT;
            S_DIV:   cmd.op = alqr_pkg::OP_DIV_STEP;
            S_DUTY:  cmd.op = alqr_pkg::OP_DUTY;
            S_PUB:   cmd.op = out_free ? alqr_pkg::OP_PUBLISH : alqr_pkg::OP_NOP;
            default: cmd.op = alqr_pkg::OP_NOP;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            sel_reg     <= alqr_pkg::SEL_EX2;
            idx_reg     <= '0;
            motor_reg   <= '0;
            cnt_reg     <= '0;
            s_ready_reg <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            if ((state_reg == S_PUB) && out_free)
                m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_ready)
                m_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        s_ready_reg <= 1'b0;
                        sel_reg     <= alqr_pkg::SEL_EX2;
                        idx_reg     <= '0;
                        state_reg   <= S_MLO;
                    end
                end
                S_MLO: state_reg <= S_MHI;
                S_MHI: state_reg <= S_WB;
                S_WB: begin
                    case (sel_reg)
                        alqr_pkg::SEL_EX2: begin
                            sel_reg   <= alqr_pkg::SEL_EY2;
                            state_reg <= S_MLO;
                        end
                        alqr_pkg::SEL_EY2: begin
                            sel_reg   <= alqr_pkg::SEL_TRM;
                            idx_reg   <= '0;
                            state_reg <= S_MLO;
                        end
                        alqr_pkg::SEL_TRM: begin
                            if (idx_reg == TRM_LAST) begin
                                state_reg <= S_SQLD;
                            end else begin
                                idx_reg   <= idx_reg + 3'd1;
                                state_reg <= S_MLO;
                            end
                        end
                        alqr_pkg::SEL_FORCE: begin
                            sel_reg   <= alqr_pkg::SEL_S2;
                            state_reg <= S_MLO;
                        end
                        alqr_pkg::SEL_S2: begin
                            cnt_reg   <= '0;
                            state_reg <= S_SQ;
                        end
                        alqr_pkg::SEL_HORN: begin
                            if (idx_reg == HORN_LAST)
                                sel_reg <= alqr_pkg::SEL_MV;
                            else
                                idx_reg <= idx_reg + 3'd1;
                            state_reg <= S_MLO;
                        end
                        alqr_pkg::SEL_MV: begin
                            sel_reg   <= alqr_pkg::SEL_X;
                            state_reg <= S_MLO;
                        end
                        alqr_pkg::SEL_X: begin
                            sel_reg   <= alqr_pkg::SEL_Y;
                            state_reg <= S_MLO;
                        end
                        alqr_pkg::SEL_Y:  state_reg <= S_DINIT;
                        default:          state_reg <= S_IDLE;
                    endcase
                end
                S_SQLD: begin
                    cnt_reg   <= '0;
                    state_reg <= S_SQ;
                end
                S_SQ: begin
                    if (cnt_reg == SQ_LAST)
                        state_reg <= (sel_reg == alqr_pkg::SEL_TRM) ? S_ARM : S_AINIT;
                    else
                        cnt_reg <= cnt_reg + 5'd1;
                end
                S_ARM: state_reg <= S_CHK;
                S_CHK: begin
                    if (sts.drive) begin
                        motor_reg <= '0;
                        sel_reg   <= alqr_pkg::SEL_FORCE;
                        state_reg <= S_MLO;
                    end else begin
                        state_reg <= S_PUB;
                    end
                end
                S_AINIT: begin
                    idx_reg   <= 3'd1;
                    sel_reg   <= alqr_pkg::SEL_HORN;
                    state_reg <= S_MLO;
                end
                S_DINIT: begin
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (cnt_reg == DIV_LAST)
                        state_reg <= S_DUTY;
                    else
                        cnt_reg <= cnt_reg + 5'd1;
                end
                S_DUTY: begin
                    if (motor_reg == LAST_MOTOR) begin
                        state_reg <= S_PUB;
                    end else begin
                        motor_reg <= motor_reg + 3'd1;
                        sel_reg   <= alqr_pkg::SEL_FORCE;
                        state_reg <= S_MLO;
                    end
                end
                S_PUB: begin
                    if (out_free) begin
                        s_ready_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_ready_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready_reg |-> (state_reg == S_IDLE))
        else $error("ready raised while busy");

    a_accept_drops_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready_reg)
        else $error("ready still high after accepting a transaction");

    a_publish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == alqr_pkg::OP_PUBLISH) |-> out_free)
        else $error("result overwritten before it was taken");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= SQ_LAST)
        else $error("step counter out of range");

    a_motor_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        motor_reg <= LAST_MOTOR)
        else $error("motor index past the last motor");

endmodule

FILE: rtl/attitude_lqr_motor_duty.sv
// ----------------------------------------------------------------------------
// attitude_lqr_motor_duty
// throughput: one transaction at a time; s_ready stays low until the result is published,
// and a driving sample adds force, speed, voltage and duty steps for each motor;
// set by the sequencer sharing one multiplier, square root and divider
// reset: synchronous active-low aresetn; disarms and restores register defaults
// ----------------------------------------------------------------------------
module attitude_lqr_motor_duty #(
    parameter int MOTOR_COUNT = 8
) (
    input  logic                aclk,
    input  logic                aresetn,

    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,

    // attitude sample
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [15:0]  s_roll_angle,
    input  logic signed [15:0]  s_pitch_angle,
    input  logic signed [15:0]  s_roll_rate,
    input  logic signed [15:0]  s_pitch_rate,
    input  logic signed [15:0]  s_yaw_rate,
    input  logic [15:0]         s_battery_mv,

    // motor duties
    output logic                m_valid,
    input  logic                m_ready,
    output logic [15:0]         m_duty_0,
    output logic [15:0]         m_duty_1,
    output logic [15:0]         m_duty_2,
    output logic [15:0]         m_duty_3,
    output logic [15:0]         m_duty_4,
    output logic [15:0]         m_duty_5,
    output logic [15:0]         m_duty_6,
    output logic [15:0]         m_duty_7,
    output logic                m_driving
);

    alqr_pkg::cfg_t   cfg;
    alqr_pkg::cmd_t   cmd;
    alqr_pkg::sts_t   sts;
    logic [7:0][15:0] duty;

    // register file; the user writes it only between transactions, not enforced here
    alqr_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer: error terms, torque, arming, then one motor after another when driving
    alqr_ctrl #(
        .MOTOR_COUNT (MOTOR_COUNT)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // datapath holds working values and the output register, so a result
    // can wait on m_ready while the next transaction is taken in
    alqr_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .cmd         (cmd),
        .sts         (sts),
        .roll_angle  (s_roll_angle),
        .pitch_angle (s_pitch_angle),
        .roll_rate   (s_roll_rate),
        .pitch_rate  (s_pitch_rate),
        .yaw_rate    (s_yaw_rate),
        .battery_mv  (s_battery_mv),
        .duty        (duty),
        .driving     (m_driving)
    );

    // motors past MOTOR_COUNT are never written and stay at zero
    assign m_duty_0 = duty[0];
    assign m_duty_1 = duty[1];
    assign m_duty_2 = duty[2];
    assign m_duty_3 = duty[3];
    assign m_duty_4 = duty[4];
    assign m_duty_5 = duty[5];
    assign m_duty_6 = duty[6];
    assign m_duty_7 = duty[7];

endmodule
